[src/pdsd_pkg.sv]
// ----------------------------------------------------------------------------
// pdsd_pkg
// Shared types and constants for the PDU stream deframer.
// ----------------------------------------------------------------------------
package pdsd_pkg;

    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned LEN_W     = 20;
    localparam int unsigned CNT_W     = 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PAYLOAD,
        PH_PAD,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_STATUS
    } kind_t;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_LEN_ERR = 1'b1;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] buffer_length;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] channel_id;
        logic        packet_first;
        logic        packet_last;
        logic        status;
        logic        last_result;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

[src/pdsd_byte_if.sv]
// ----------------------------------------------------------------------------
// pdsd_byte_if
// Receive byte channel: valid/ready handshake with byte and buffer length.
// ----------------------------------------------------------------------------
interface pdsd_byte_if;
    import pdsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] buffer_length;

    modport source (output valid, output data_byte, output buffer_length, input ready);
    modport sink   (input valid, input data_byte, input buffer_length, output ready);
endinterface

[src/pdsd_result_if.sv]
// ----------------------------------------------------------------------------
// pdsd_result_if
// Result channel: valid/ready handshake with tagged payload and status.
// ----------------------------------------------------------------------------
interface pdsd_result_if;
    import pdsd_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] channel_id;
    logic        packet_first;
    logic        packet_last;
    logic        status;
    logic        last_result;

    modport source (
        output valid, output kind, output payload_byte, output channel_id,
        output packet_first, output packet_last, output status, output last_result,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input channel_id,
        input packet_first, input packet_last, input status, input last_result,
        output ready
    );
endinterface

[src/pdu_stream_deframer.sv]
// ----------------------------------------------------------------------------
// pdu_stream_deframer
// Splits a receive byte stream into tagged payload bytes and buffer status.
// ----------------------------------------------------------------------------
// Takes one buffer byte per transfer and deframes it in a single registered
// pass: a byte sits in the input register, the phase logic updates the
// deframing state, and its results land in the output register. Throughput
// is one byte per cycle while the result channel is ready and the spill slot
// is empty. A byte that yields two results (a payload byte or empty-packet
// notice that also ends the buffer) parks the second result in a spill slot,
// and the input pauses while that slot drains. Length errors are reported
// by a status result, then the rest of the buffer is drained without
// output.
module pdu_stream_deframer (
    input  logic                clk,
    input  logic                rst_n,
    pdsd_byte_if.sink           byte_ch,
    pdsd_result_if.source       result_ch
);
    import pdsd_pkg::*;

    in_item_t in_item;
    push_t    push;
    logic     space;
    res_t     res;

    assign in_item.data_byte     = byte_ch.data_byte;
    assign in_item.buffer_length = byte_ch.buffer_length;

    pdsd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (byte_ch.ready),
        .in_item  (in_item),
        .space    (space),
        .push     (push)
    );

    pdsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .out_item  (res)
    );

    assign result_ch.kind         = res.kind;
    assign result_ch.payload_byte = res.payload_byte;
    assign result_ch.channel_id   = res.channel_id;
    assign result_ch.packet_first = res.packet_first;
    assign result_ch.packet_last  = res.packet_last;
    assign result_ch.status       = res.status;
    assign result_ch.last_result  = res.last_result;

endmodule

[src/pdsd_core.sv]
// ----------------------------------------------------------------------------
// pdsd_core
// Input register and per-byte deframing: phase tracking and result build.
// ----------------------------------------------------------------------------
module pdsd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdsd_pkg::in_item_t in_item,
    input  logic              space,
    output pdsd_pkg::push_t   push
);
    import pdsd_pkg::*;

    logic             in_vld_reg;
    in_item_t         in_reg;
    logic             fire;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] br_reg;
    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [15:0]      pl_reg, pl_next;
    logic [7:0]       skip_reg, skip_next;
    logic [31:0]      chan_reg, chan_next;
    logic [2:0]       pad_reg;

    logic             start;
    logic [LEN_W-1:0] br_base, br1;
    phase_t           ph_cur, ph_mid;
    logic [CNT_W-1:0] pc_cur, pc_mid;
    logic [2:0]       hdr_c;
    logic             hdr_end;
    logic [16:0]      need;
    logic             short_buf;
    logic [2:0]       pad_new, pad_eff;
    logic [16:0]      pc_inc;
    logic             buf_end;
    phase_t           after_pay, after_skip;
    logic [7:0]       b;

    assign fire     = in_vld_reg && space;
    assign in_ready = !in_vld_reg || fire;
    assign b        = in_reg.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_item;
        end
    end

    assign start   = (phase_reg == PH_IDLE);
    assign br_base = start ? ((in_reg.buffer_length == '0) ? LEN_W'(1) : in_reg.buffer_length)
                           : br_reg;
    assign br1     = br_base - LEN_W'(1);
    assign ph_cur  = start ? PH_HEADER : phase_reg;
    assign pc_cur  = start ? '0 : pc_reg;
    assign hdr_c   = pc_cur[2:0];
    assign hdr_end = (ph_cur == PH_HEADER) && (hdr_c == 3'(HDR_BYTES - 1));
    assign need    = {1'b0, pl_reg} + {9'b0, skip_reg};
    assign short_buf = br1 < {3'b0, need};
    assign pad_new = 3'(3'd0 - need[2:0]);
    assign pad_eff = hdr_end ? pad_new : pad_reg;
    assign pc_inc  = {1'b0, pc_cur} + 17'd1;
    assign buf_end = (br1 == '0) && (ph_cur != PH_DRAIN) && !(hdr_end && short_buf);
    assign after_pay  = (pad_eff != 3'd0) ? PH_PAD : PH_HEADER;
    assign after_skip = (pl_reg != 16'd0) ? PH_PAYLOAD : after_pay;

    // header field capture
    always_comb
    begin
        pl_next   = pl_reg;
        skip_next = skip_reg;
        chan_next = chan_reg;
        if (ph_cur == PH_HEADER)
        begin
            unique case (hdr_c)
                3'd0:    pl_next = {b, 8'h00};
                3'd1:    pl_next = {pl_reg[15:8], pl_reg[7:0] | b};
                3'd3:    skip_next = b;
                3'd4:    chan_next = {24'h0, b};
                3'd5:    chan_next = chan_reg | {16'h0, b, 8'h0};
                3'd6:    chan_next = chan_reg | {8'h0, b, 16'h0};
                3'd7:    chan_next = chan_reg | {b, 24'h0};
                default: ;
            endcase
        end
    end

    // next phase and count
    always_comb
    begin
        ph_mid = ph_cur;
        pc_mid = pc_cur;
        unique case (ph_cur)
            PH_DRAIN:
            begin
                if (br1 == '0)
                begin
                    ph_mid = PH_IDLE;
                end
            end
            PH_HEADER:
            begin
                pc_mid = CNT_W'(hdr_c) + CNT_W'(1);
                if (hdr_end)
                begin
                    pc_mid = '0;
                    if (short_buf)
                    begin
                        ph_mid = (br1 != '0) ? PH_DRAIN : PH_IDLE;
                    end
                    else if (skip_reg != 8'd0)
                    begin
                        ph_mid = PH_SKIP;
                    end
                    else
                    begin
                        ph_mid = after_skip;
                    end
                end
            end
            PH_SKIP:
            begin
                pc_mid = pc_inc[CNT_W-1:0];
                if (pc_inc >= {9'b0, skip_reg})
                begin
                    pc_mid = '0;
                    ph_mid = after_skip;
                end
            end
            PH_PAYLOAD:
            begin
                pc_mid = pc_inc[CNT_W-1:0];
                if (pc_inc >= {1'b0, pl_reg})
                begin
                    pc_mid = '0;
                    ph_mid = after_pay;
                end
            end
            PH_PAD:
            begin
                pc_mid = pc_inc[CNT_W-1:0];
                if (pc_inc >= {14'b0, pad_reg})
                begin
                    pc_mid = '0;
                    ph_mid = PH_HEADER;
                end
            end
            default: ;
        endcase

        phase_next = ph_mid;
        pc_next    = pc_mid;
        if (buf_end)
        begin
            phase_next = PH_IDLE;
            pc_next    = '0;
        end
    end

    // results
    always_comb
    begin
        res_t r;
        res_t s;
        r = '0;
        s = '0;
        push = '0;
        s.kind   = KIND_STATUS;
        s.status = ((ph_mid == PH_HEADER) && (pc_mid != '0)) ? ST_LEN_ERR : ST_OK;
        s.last_result = 1'b1;

        if (hdr_end && short_buf)
        begin
            r.kind        = KIND_STATUS;
            r.status      = ST_LEN_ERR;
            r.last_result = 1'b1;
            push.count    = 2'd1;
            push.r0       = r;
        end
        else if ((hdr_end && (pl_reg == 16'd0)) || (ph_cur == PH_PAYLOAD))
        begin
            r.kind       = (ph_cur == PH_PAYLOAD) ? KIND_PAYLOAD : KIND_EMPTY;
            r.channel_id = chan_next;
            if (ph_cur == PH_PAYLOAD)
            begin
                r.payload_byte = b;
                r.packet_first = (pc_cur == '0);
                r.packet_last  = (pc_inc >= {1'b0, pl_reg});
            end
            r.last_result = !buf_end;
            push.r0       = r;
            push.count    = 2'd1;
            if (buf_end)
            begin
                push.r1    = s;
                push.count = 2'd2;
            end
        end
        else if (buf_end)
        begin
            push.r0    = s;
            push.count = 2'd1;
        end

        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            br_reg    <= '0;
            pc_reg    <= '0;
            pl_reg    <= '0;
            skip_reg  <= '0;
            chan_reg  <= '0;
            pad_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            br_reg    <= br1;
            pc_reg    <= pc_next;
            pl_reg    <= pl_next;
            skip_reg  <= skip_next;
            chan_reg  <= chan_next;
            if (hdr_end && !short_buf)
            begin
                pad_reg <= pad_new;
            end
        end
    end

endmodule

[src/pdsd_out_stage.sv]
// ----------------------------------------------------------------------------
// pdsd_out_stage
// Result register with one spill slot; takes up to two results per transfer.
// ----------------------------------------------------------------------------
module pdsd_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  pdsd_pkg::push_t push,
    output logic            space,
    output logic            out_valid,
    input  logic            out_ready,
    output pdsd_pkg::res_t  out_item
);
    import pdsd_pkg::*;

    logic out_vld_reg;
    logic spill_vld_reg;
    res_t out_reg;
    res_t spill_reg;
    logic pop;

    assign pop       = out_vld_reg && out_ready;
    assign space     = !spill_vld_reg && (!out_vld_reg || pop);
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            spill_vld_reg <= 1'b0;
        end
        else if (spill_vld_reg)
        begin
            if (pop)
            begin
                spill_vld_reg <= 1'b0;
            end
        end
        else if (push.count != 2'd0)
        begin
            out_vld_reg   <= 1'b1;
            spill_vld_reg <= (push.count == 2'd2);
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spill_vld_reg)
        begin
            if (pop)
            begin
                out_reg <= spill_reg;
            end
        end
        else if (push.count != 2'd0)
        begin
            out_reg   <= push.r0;
            spill_reg <= push.r1;
        end
    end

endmodule

[src/pdsd_checker.sv]
// ----------------------------------------------------------------------------
// pdsd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
module pdsd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input pdsd_pkg::kind_t   kind,
    input logic [7:0]        payload_byte,
    input logic [31:0]       channel_id,
    input logic              packet_first,
    input logic              packet_last,
    input logic              status,
    input logic              last_result
);
    import pdsd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STATUS) |->
            (channel_id == '0) && (payload_byte == '0) && !packet_first
            && !packet_last && last_result)
        else $error("buffer status carries packet fields");

    a_no_status_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_STATUS) |-> (status == ST_OK))
        else $error("status set on packet result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_PAYLOAD) || (kind == KIND_EMPTY)
            || (kind == KIND_STATUS))
        else $error("undefined result kind");

endmodule

bind pdu_stream_deframer pdsd_checker u_pdsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .kind         (result_ch.kind),
    .payload_byte (result_ch.payload_byte),
    .channel_id   (result_ch.channel_id),
    .packet_first (result_ch.packet_first),
    .packet_last  (result_ch.packet_last),
    .status       (result_ch.status),
    .last_result  (result_ch.last_result)
);
